/* design/clt_pkg.sv */
package clt_pkg;

   // Longest token (word or number) in characters.
   localparam int MAX_TOKEN_LEN = 12;
   // Keyword entries in use; the ROM has KW_SLOTS places.
   localparam int KEYWORD_COUNT = 21;
   localparam int KW_SLOTS = 32;
   // Default response queue depth, at least 2.
   localparam int RSP_DEPTH_DEFAULT = 4;

   // Response kinds.
   localparam logic [2:0] K_CMD = 3'd0;
   localparam logic [2:0] K_NUM = 3'd1;
   localparam logic [2:0] K_NEG = 3'd2;
   localparam logic [2:0] K_EOL = 3'd3;
   localparam logic [2:0] K_BAD = 3'd4;
   localparam logic [2:0] K_UNK = 3'd5;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  command;
      logic [15:0] number;
      logic        last;
   } rsp_type;

   // Up to two responses per request.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_WORD   = 4'b0010,
      MODE_NUMBER = 4'b0100,
      MODE_MINUS  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] k0;
      logic [7:0] k1;
      logic [3:0] len;
   } kw_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] idx;
   } kw_hit_type;

   function automatic kw_type kw_entry(input logic [4:0] idx);
      kw_type e;
      case (idx)
         5'd0:    e = '{"o", "f", 4'd3};
         5'd1:    e = '{"o", "n", 4'd2};
         5'd2:    e = '{"l", "e", 4'd3};
         5'd3:    e = '{"r", "e", 4'd3};
         5'd4:    e = '{"g", "r", 4'd5};
         5'd5:    e = '{"d", "1", 4'd3};
         5'd6:    e = '{"s", "e", 4'd3};
         5'd7:    e = '{"b", "l", 4'd5};
         5'd8:    e = '{"l", "e", 4'd4};
         5'd9:    e = '{"s", "t", 4'd6};
         5'd10:   e = '{"h", "e", 4'd4};
         5'd11:   e = '{"v", "e", 4'd7};
         5'd12:   e = '{"r", "g", 4'd2};
         5'd13:   e = '{"c", "l", 4'd5};
         5'd14:   e = '{"a", "d", 4'd3};
         5'd15:   e = '{"t", "e", 4'd4};
         5'd16:   e = '{"h", "i", 4'd7};
         5'd17:   e = '{"e", "e", 4'd6};
         5'd18:   e = '{"m", "a", 4'd3};
         5'd19:   e = '{"m", "i", 4'd3};
         5'd20:   e = '{"r", "g", 4'd3};
         default: e = '0;
      endcase
      return e;
   endfunction

   // Parallel match; lowest index wins.
   function automatic kw_hit_type kw_lookup(input logic [7:0] k0, input logic [7:0] k1,
                                            input logic [3:0] len);
      kw_hit_type r;
      kw_type     e;
      r = '0;
      for (int i = KW_SLOTS - 1; i >= 0; i--) begin
         e = kw_entry(5'(i));
         if (i < KEYWORD_COUNT && e.k0 == k0 && e.k1 == k1 && e.len == len) begin
            r.hit = 1'b1;
            r.idx = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

/* design/clt_scan.sv */
module clt_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  clt_pkg::req_type  item,
   output clt_pkg::push_type push
);

   clt_pkg::mode_type mode_ff, mode_in;
   logic              discard_ff, discard_in;
   logic [7:0]        first_ff, first_in;
   logic [7:0]        second_ff, second_in;
   logic [3:0]        token_len_ff, token_len_in;
   logic [15:0]       acc_ff, acc_in;

   logic [7:0]          c;
   logic [7:0]          c_low;
   logic                is_end;
   logic                is_letter;
   logic                is_digit;
   logic                is_minus;
   logic                len_full;
   logic [15:0]         acc_step;
   clt_pkg::kw_hit_type kw;
   clt_pkg::rsp_type    flush_rsp;
   logic                flush_unknown;
   clt_pkg::rsp_type    eol_rsp;
   clt_pkg::rsp_type    bad_rsp;
   clt_pkg::rsp_type    neg_rsp;
   logic                add;
   logic                acc_load;
   logic                clear;
   logic                bad;

   assign c         = item.ch;
   assign is_end    = item.line_end || (c == 8'h00);
   assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   assign is_digit  = (c >= "0" && c <= "9");
   assign is_minus  = (c == "-");
   assign c_low     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   assign len_full  = token_len_ff >= 4'(clt_pkg::MAX_TOKEN_LEN);
   // acc * 10 + digit, wraps at 16 bits
   assign acc_step  = (acc_ff << 3) + (acc_ff << 1) + {12'd0, c[3:0]};

   assign kw = clt_pkg::kw_lookup(first_ff, second_ff, token_len_ff);

   assign eol_rsp = '{kind: clt_pkg::K_EOL, command: 5'd0, number: 16'd0, last: 1'b1};
   assign bad_rsp = '{kind: clt_pkg::K_BAD, command: 5'd0, number: 16'd0, last: 1'b1};
   assign neg_rsp = '{kind: clt_pkg::K_NEG, command: 5'd0, number: 16'd0, last: 1'b0};

   always_comb begin
      flush_unknown = 1'b0;
      if (mode_ff == clt_pkg::MODE_NUMBER) begin
         flush_rsp = '{kind: clt_pkg::K_NUM, command: 5'd0, number: acc_ff, last: 1'b0};
      end else if (kw.hit) begin
         flush_rsp = '{kind: clt_pkg::K_CMD, command: kw.idx, number: 16'd0, last: 1'b0};
      end else begin
         flush_rsp = '{kind: clt_pkg::K_UNK, command: 5'd0, number: 16'd0, last: 1'b1};
         flush_unknown = 1'b1;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      discard_in   = discard_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      token_len_in = token_len_ff;
      acc_in       = acc_ff;
      push         = '0;
      add          = 1'b0;
      acc_load     = 1'b0;
      clear        = 1'b0;
      bad          = 1'b0;

      if (step) begin
         if (is_end) begin
            if (!discard_ff) begin
               if (token_len_ff != 4'd0) begin
                  push.first = flush_rsp;
                  push.count = 2'd1;
                  if (!flush_unknown) begin
                     push.second = eol_rsp;
                     push.count  = 2'd2;
                  end
               end else begin
                  push.first = eol_rsp;
                  push.count = 2'd1;
               end
            end
            mode_in    = clt_pkg::MODE_IDLE;
            discard_in = 1'b0;
            clear      = 1'b1;
         end else if (!discard_ff) begin
            unique case (mode_ff)
               clt_pkg::MODE_IDLE: begin
                  if (is_letter) begin
                     add     = 1'b1;
                     mode_in = clt_pkg::MODE_WORD;
                  end else if (is_digit) begin
                     add      = 1'b1;
                     acc_load = 1'b1;
                     mode_in  = clt_pkg::MODE_NUMBER;
                  end else if (is_minus) begin
                     push.first = neg_rsp;
                     push.count = 2'd1;
                     mode_in    = clt_pkg::MODE_MINUS;
                  end
               end
               clt_pkg::MODE_WORD: begin
                  if (is_letter || is_digit) begin
                     if (len_full) bad = 1'b1;
                     else add = 1'b1;
                  end else if (is_minus) begin
                     bad = 1'b1;
                  end else begin
                     push.first = flush_rsp;
                     push.count = 2'd1;
                     if (flush_unknown) discard_in = 1'b1;
                     mode_in = clt_pkg::MODE_IDLE;
                     clear   = 1'b1;
                  end
               end
               clt_pkg::MODE_NUMBER: begin
                  if (is_digit) begin
                     if (len_full) bad = 1'b1;
                     else begin
                        add      = 1'b1;
                        acc_load = 1'b1;
                     end
                  end else if (is_letter || is_minus) begin
                     bad = 1'b1;
                  end else begin
                     push.first = flush_rsp;
                     push.count = 2'd1;
                     mode_in    = clt_pkg::MODE_IDLE;
                     clear      = 1'b1;
                  end
               end
               clt_pkg::MODE_MINUS: begin
                  if (is_digit) begin
                     add      = 1'b1;
                     acc_load = 1'b1;
                     mode_in  = clt_pkg::MODE_NUMBER;
                  end else begin
                     bad = 1'b1;
                  end
               end
               default: bad = 1'b1;
            endcase
         end
      end

      if (bad) begin
         push.first = bad_rsp;
         push.count = 2'd1;
         discard_in = 1'b1;
         mode_in    = clt_pkg::MODE_IDLE;
         clear      = 1'b1;
      end
      if (acc_load) acc_in = acc_step;
      if (add) begin
         if (token_len_ff == 4'd0) first_in = c_low;
         if (token_len_ff == 4'd1) second_in = c_low;
         token_len_in = token_len_ff + 4'd1;
      end
      if (clear) begin
         first_in     = 8'd0;
         second_in    = 8'd0;
         token_len_in = 4'd0;
         acc_in       = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= clt_pkg::MODE_IDLE;
         discard_ff   <= 1'b0;
         first_ff     <= 8'd0;
         second_ff    <= 8'd0;
         token_len_ff <= 4'd0;
         acc_ff       <= 16'd0;
      end else begin
         mode_ff      <= mode_in;
         discard_ff   <= discard_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         token_len_ff <= token_len_in;
         acc_ff       <= acc_in;
      end
   end

   // line end always leaves a clean, idle tokenizer
   assert property (@(posedge clock) disable iff (reset)
      step && is_end |=> !discard_ff && mode_ff == clt_pkg::MODE_IDLE && token_len_ff == 4'd0)
      else $error("tokenizer not cleared after line end");

   // while discarding no token is held
   assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> mode_ff == clt_pkg::MODE_IDLE && token_len_ff == 4'd0 && acc_ff == 16'd0)
      else $error("token state held while discarding");

   // a closing response is never followed by another in the same request
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 && push.first.last |-> push.count == 2'd1)
      else $error("response pushed after a closing response");

endmodule

/* design/clt_rsp_fifo.sv */
module clt_rsp_fifo #(
   parameter int DEPTH = clt_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  clt_pkg::push_type push,
   input  logic              pop,
   output logic              room2,
   output logic              rsp_valid,
   output clt_pkg::rsp_type  rsp_item
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   clt_pkg::rsp_type entries_ff [DEPTH];
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [PW-1:0]    wr_ptr_next;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   assign wr_ptr_next = ptr_inc(wr_ptr_ff);
   assign room2       = count_ff <= CW'(DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entries_ff[wr_ptr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // pushes only arrive when two slots are free
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= CW'(DEPTH - 2))
      else $error("response queue overrun");

endmodule

/* design/command_line_tokenizer_core.sv */
// Path: an accepted request waits in the input register; when it steps, its
//   responses enter the response queue, a line end's second one after the first.
// Throughput: one request per cycle while the queue can take two responses, else
//   the request stalls; the response queue has RSP_DEPTH entries.
// Reset (synchronous, active high): tokenizer idle with no token, discard off,
//   input register and response queue empty.
module command_line_tokenizer_core #(
   parameter int RSP_DEPTH = clt_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  clt_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output clt_pkg::rsp_type rsp_item
);

   // Input register: holds one request until the tokenizer can take it.
   logic              in_valid_ff;
   clt_pkg::req_type  in_ff;
   logic              room2;
   logic              step;
   logic              pop;
   clt_pkg::push_type push;

   // A request steps the tokenizer only when the queue can take two responses,
   // so a line end with a pending token never overflows it.
   assign step      = in_valid_ff && room2;
   // Stall comes from registered state only, never from req_valid.
   assign req_stall = in_valid_ff && !room2;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) in_ff <= req_item;
   end

   // Character class, action decode, token state and keyword match.
   clt_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_ff),
      .push  (push)
   );

   // Response queue: up to two writes a cycle, one read.
   clt_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .room2     (room2),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // a stalled request stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_ff))
      else $error("held request lost from input register");

   // nothing is pushed without a request being stepped
   assert property (@(posedge clock) disable iff (reset)
      !step |-> push.count == 2'd0)
      else $error("response pushed without a request");

endmodule

/* verif/command_line_tokenizer_core_test.sv */
package clt_test_pkg;
   import clt_pkg::*;

   typedef enum logic [1:0] {
      CLS_LETTER,
      CLS_DIGIT,
      CLS_OTHER,
      CLS_MINUS
   } char_class_t;

   typedef enum logic [2:0] {
      ACT_SKIP,
      ACT_APPEND,
      ACT_DIGIT,
      ACT_MINUS,
      ACT_FLUSH,
      ACT_BAD
   } action_t;

   typedef struct packed {
      logic [7:0] k0;
      logic [7:0] k1;
      logic [3:0] len;
   } keyword_key_t;

   function automatic char_class_t classify(input logic [7:0] c);
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CLS_LETTER;
      if (c >= "0" && c <= "9") return CLS_DIGIT;
      if (c == "-") return CLS_MINUS;
      return CLS_OTHER;
   endfunction

   // Keyword table: first two key characters (lower case) and length.
   function automatic keyword_key_t keyword_key(input int idx);
      case (idx)
         0:       return '{"o", "f", 4'd3};
         1:       return '{"o", "n", 4'd2};
         2:       return '{"l", "e", 4'd3};
         3:       return '{"r", "e", 4'd3};
         4:       return '{"g", "r", 4'd5};
         5:       return '{"d", "1", 4'd3};
         6:       return '{"s", "e", 4'd3};
         7:       return '{"b", "l", 4'd5};
         8:       return '{"l", "e", 4'd4};
         9:       return '{"s", "t", 4'd6};
         10:      return '{"h", "e", 4'd4};
         11:      return '{"v", "e", 4'd7};
         12:      return '{"r", "g", 4'd2};
         13:      return '{"c", "l", 4'd5};
         14:      return '{"a", "d", 4'd3};
         15:      return '{"t", "e", 4'd4};
         16:      return '{"h", "i", 4'd7};
         17:      return '{"e", "e", 4'd6};
         18:      return '{"m", "a", 4'd3};
         19:      return '{"m", "i", 4'd3};
         20:      return '{"r", "g", 4'd3};
         default: return '0;
      endcase
   endfunction

   class tokenizer_mirror;
      mode_type    mode;
      bit          discarding;
      logic [7:0]  key0;
      logic [7:0]  key1;
      logic [3:0]  length;
      logic [15:0] value;
      rsp_type     expected_tokens[$];
      int          mismatches;
      int          checked;
      int          kind_seen[8];

      function new();
         reset_state();
         mismatches = 0;
         checked = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
      endfunction

      function void clear_token();
         key0 = '0;
         key1 = '0;
         length = '0;
         value = '0;
      endfunction

      function void reset_state();
         mode = MODE_IDLE;
         discarding = 1'b0;
         clear_token();
      endfunction

      function void emit(logic [2:0] kind, logic [4:0] cmd, logic [15:0] num, logic last);
         rsp_type t;
         t.kind = kind;
         t.command = cmd;
         t.number = num;
         t.last = last;
         expected_tokens.push_back(t);
      endfunction

      function void close_with_error();
         emit(K_BAD, '0, '0, 1'b1);
         discarding = 1'b1;
         mode = MODE_IDLE;
         clear_token();
      endfunction

      function int find_keyword();
         keyword_key_t e;
         for (int i = 0; i < KEYWORD_COUNT; i++) begin
            e = keyword_key(i);
            if (e.k0 == key0 && e.k1 == key1 && e.len == length) return i;
         end
         return -1;
      endfunction

      // Emits the pending token; 0 means it was an unknown word.
      function bit emit_pending();
         int idx;
         if (mode == MODE_NUMBER) begin
            emit(K_NUM, '0, value, 1'b0);
            return 1'b1;
         end
         idx = find_keyword();
         if (idx < 0) begin
            emit(K_UNK, '0, '0, 1'b1);
            return 1'b0;
         end
         emit(K_CMD, 5'(idx), '0, 1'b0);
         return 1'b1;
      endfunction

      function void append(logic [7:0] c);
         logic [7:0] lc;
         lc = (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
         if (length == 0) key0 = lc;
         else if (length == 1) key1 = lc;
         length = length + 4'd1;
      endfunction

      function action_t next_action(char_class_t cls);
         case (mode)
            MODE_IDLE: begin
               case (cls)
                  CLS_LETTER: return ACT_APPEND;
                  CLS_DIGIT:  return ACT_DIGIT;
                  CLS_MINUS:  return ACT_MINUS;
                  default:    return ACT_SKIP;
               endcase
            end
            MODE_WORD: begin
               case (cls)
                  CLS_LETTER, CLS_DIGIT: return ACT_APPEND;
                  CLS_OTHER:             return ACT_FLUSH;
                  default:               return ACT_BAD;
               endcase
            end
            MODE_NUMBER: begin
               case (cls)
                  CLS_DIGIT: return ACT_DIGIT;
                  CLS_OTHER: return ACT_FLUSH;
                  default:   return ACT_BAD;
               endcase
            end
            default: begin
               return (cls == CLS_DIGIT) ? ACT_DIGIT : ACT_BAD;
            end
         endcase
      endfunction

      function void note_request(req_type r);
         bit      ok;
         action_t act;
         if (r.line_end || r.ch == 8'd0) begin
            if (!discarding) begin
               ok = 1'b1;
               if (length != 0) ok = emit_pending();
               if (ok) emit(K_EOL, '0, '0, 1'b1);
            end
            reset_state();
            return;
         end
         if (discarding) return;
         act = next_action(classify(r.ch));
         case (act)
            ACT_SKIP: mode = MODE_IDLE;
            ACT_APPEND: begin
               if (length >= MAX_TOKEN_LEN) close_with_error();
               else begin
                  append(r.ch);
                  mode = MODE_WORD;
               end
            end
            ACT_DIGIT: begin
               if (length >= MAX_TOKEN_LEN) close_with_error();
               else begin
                  value = 16'(int'(value) * 10 + int'(r.ch) - int'("0"));
                  append(r.ch);
                  mode = MODE_NUMBER;
               end
            end
            ACT_MINUS: begin
               emit(K_NEG, '0, '0, 1'b0);
               mode = MODE_MINUS;
            end
            ACT_FLUSH: begin
               if (!emit_pending()) begin
                  discarding = 1'b1;
                  mode = MODE_IDLE;
                  clear_token();
               end else begin
                  clear_token();
                  mode = MODE_IDLE;
               end
            end
            default: close_with_error();
         endcase
      endfunction

      function void compare_token(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: kind %0d command %0d number %0d last %0d",
                        got.kind, got.command, got.number, got.last);
            return;
         end
         want = expected_tokens.pop_front();
         kind_seen[want.kind]++;
         if (got.kind !== want.kind || got.command !== want.command ||
             got.number !== want.number || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"response mismatch: kind %0d/%0d command %0d/%0d ",
                         "number %0d/%0d last %0d/%0d (expected/actual)"},
                        want.kind, got.kind, want.command, got.command,
                        want.number, got.number, want.last, got.last);
         end
      endfunction
   endclass

endpackage

module command_line_tokenizer_core_test;
   import clt_pkg::*;
   import clt_test_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_CYCLES = 300;  // long receiver hold-off
   localparam int DRAIN_GUARD = 50000;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   tokenizer_mirror mirror = new();

   int send_idle_pct = 0;   // sender gap chance, owned by the stimulus process
   int stall_pct = 0;       // receiver stall chance, written by NBA
   int holds_asked = 0;     // bumped by the stimulus to request a long hold-off
   int holds_served = 0;
   int hold_left = 0;
   int sent = 0;

   command_line_tokenizer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #(20 * 400000);
      $display("tokenizer test: timed out with %0d responses outstanding",
               mirror.expected_tokens.size());
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stall, or a long hold-off counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_asked != holds_served) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: samples pre-edge values, so no ordering race with the drivers.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) mirror.note_request(req_item);
         if (rsp_valid && !rsp_stall) mirror.compare_token(rsp_item);
      end
   end

   // Offer one request, with a random gap first; returns at its accepting edge.
   task automatic send_request(input logic [7:0] c, input logic le);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{ch: c, line_end: le};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // Sender pauses until every expected response is back. Always advances a cycle
   // so valid is never lowered and raised in one step.
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.expected_tokens.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
   endtask

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = 8'($urandom_range(25));
      return $urandom_range(1) ? 8'("a" + c) : 8'("A" + c);
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_alnum();
      return $urandom_range(2) == 0 ? rand_digit() : rand_letter();
   endfunction

   // Separator: half the time a plain one, else any other-class byte (high bytes too).
   function automatic logic [7:0] rand_other();
      logic [7:0] c;
      case ($urandom_range(3))
         0: return " ";
         1: return ",";
         default: begin
            c = 8'($urandom_range(1, 255));
            while (classify(c) != CLS_OTHER) c = 8'($urandom_range(1, 255));
            return c;
         end
      endcase
   endfunction

   // Token length: mostly short, sometimes at or just past the limit.
   function automatic int rand_len();
      case ($urandom_range(19))
         0:       return MAX_TOKEN_LEN + 1;
         1:       return MAX_TOKEN_LEN;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(1)) return 8'(c - 8'd32);
      return c;
   endfunction

   task automatic send_number(input int n);
      repeat (n) send_request(rand_digit(), 1'b0);
   endtask

   // One command line: mostly well-formed tokens with random content,
   // a tenth of the lines pure noise.
   task automatic send_line();
      keyword_key_t k;
      int           n;
      int           len;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 12))
            send_request(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
         n = $urandom_range(0, 5);
         for (int t = 0; t < n; t++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: begin
                  // keyword, sometimes one character off in length
                  k = keyword_key($urandom_range(KEYWORD_COUNT - 1));
                  len = k.len;
                  if ($urandom_range(6) == 0) len = len + ($urandom_range(1) ? 1 : -1);
                  send_request(flip_case(k.k0), 1'b0);
                  if (len > 1) send_request(flip_case(k.k1), 1'b0);
                  for (int i = 2; i < len; i++) send_request(rand_alnum(), 1'b0);
               end
               4, 5: send_number(rand_len());
               6: begin
                  send_request("-", 1'b0);
                  if ($urandom_range(4) != 0) send_number(rand_len());
               end
               7: begin
                  len = rand_len();
                  send_request(rand_letter(), 1'b0);
                  for (int i = 1; i < len; i++) send_request(rand_alnum(), 1'b0);
               end
               8: send_request(rand_other(), 1'b0);
               default: send_request(8'($urandom_range(1, 255)), 1'b0);
            endcase
            // missing separator lets tokens run into each other
            if ($urandom_range(6) != 0) send_request(rand_other(), 1'b0);
         end
         if ($urandom_range(3) == 0) send_request(8'd0, 1'b0);
         else send_request(8'($urandom_range(255)), 1'b1);
      end
   endtask

   initial begin
      int goal;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling.
      send_request("O", 1'b0);      // upper case keyword off
      send_request("f", 1'b0);
      send_request("F", 1'b0);
      send_request(8'hFF, 1'b0);    // high byte acts as separator
      send_request("-", 1'b0);      // negative marker, then number
      send_request("6", 1'b0);
      send_request("5", 1'b0);
      send_request(8'h80, 1'b0);
      send_request("-", 1'b0);      // pending minus at line end
      send_request("x", 1'b1);      // line_end set, character ignored
      send_request("x", 1'b0);      // one-letter word never matches
      send_request(8'd0, 1'b0);     // zero byte ends the line
      send_request("7", 1'b0);      // letter after digit is an error
      send_request("a", 1'b0);
      send_request("b", 1'b0);      // discarded
      send_request(8'd0, 1'b1);     // clears discard, no response
      send_request("z", 1'b0);      // unknown word at separator
      send_request("z", 1'b0);
      send_request(" ", 1'b0);
      send_request("q", 1'b0);
      send_request("1", 1'b1);
      send_request("-", 1'b0);      // minus after minus
      send_request("-", 1'b0);
      send_request(" ", 1'b1);
      send_request(8'hFF, 1'b1);    // empty line
      wait_drained();

      // Random part in four idling phases.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
               holds_asked <= holds_asked + 1;  // fill the block up
            end
            1: begin
               send_idle_pct = 61;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 61;
            end
            default: begin
               send_idle_pct = 31;
               stall_pct <= 31;
            end
         endcase
         goal = sent + RANDOM_ITEMS / 4;
         while (sent < goal) begin
            send_line();
            if (phase == 2 && sent >= goal - RANDOM_ITEMS / 8 && $urandom_range(7) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mirror.expected_tokens.size() != 0) begin
         $display("%0d expected responses never arrived", mirror.expected_tokens.size());
         mirror.mismatches += mirror.expected_tokens.size();
      end

      $display("tokenizer run: %0d requests, %0d responses checked, %0d mismatches",
               sent, mirror.checked, mirror.mismatches);
      $display({"  kinds seen: %0d command, %0d number, %0d minus, ",
                "%0d eol, %0d bad, %0d unknown"},
               mirror.kind_seen[K_CMD], mirror.kind_seen[K_NUM], mirror.kind_seen[K_NEG],
               mirror.kind_seen[K_EOL], mirror.kind_seen[K_BAD], mirror.kind_seen[K_UNK]);
      if (mirror.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
